### hdl/dkrm_pkg.sv
`timescale 1ns / 1ps
package dkrm_pkg;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned CNT_W = 6;
  localparam int unsigned KW_W = 5;

  localparam logic [CNT_W-1:0] MAX_PAD_DIGITS = 6'd31;
  localparam logic [CNT_W-1:0] CNT_SAT = 6'd63;
  localparam logic [KW_W-1:0] KW_DEFAULT = 5'd16;
  localparam logic [VAL_W-1:0] RS_DEFAULT = 64'd1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Configuration register indexes
  localparam logic CFG_BUCKET_DIV = 1'b0;
  localparam logic CFG_DIGIT_SPAN = 1'b1;

  // One finished key handed from the parser to the divide engine
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] digits;
  } key_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PAD,
    BK_DIV,
    BK_DONE
  } bk_state_t;

  // v * 10 modulo 2^64 as two shifts and one add
  function automatic logic [VAL_W-1:0] times10(input logic [VAL_W-1:0] v);
    times10 = {v[VAL_W-4:0], 3'b000} + {v[VAL_W-2:0], 1'b0};
  endfunction

endpackage

### hdl/dkrm_front.sv
`timescale 1ns / 1ps
module dkrm_front
  import dkrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       key_byte,
  input  logic             byte_present,
  input  logic             last_byte,
  output logic             q_push,
  output key_entry_t       q_data
);

  logic [VAL_W-1:0] acc_r, acc_nxt, acc_upd;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic             stop_r, stop_nxt, stop_upd;
  logic             is_digit;
  logic [7:0]       digit_full;

  assign is_digit   = (key_byte >= CHAR_ZERO) && (key_byte <= CHAR_NINE);
  assign digit_full = key_byte - CHAR_ZERO;

  always_comb begin
    acc_upd  = acc_r;
    cnt_upd  = cnt_r;
    stop_upd = stop_r;
    if (byte_present && !stop_r) begin
      if (is_digit) begin
        acc_upd = times10(acc_r) + {{(VAL_W-4){1'b0}}, digit_full[3:0]};
        if (cnt_r != CNT_SAT) begin
          cnt_upd = cnt_r + 6'd1;
        end
      end else begin
        stop_upd = 1'b1;
      end
    end

    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    q_push   = 1'b0;
    if (accept) begin
      if (last_byte) begin
        q_push   = 1'b1;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        stop_nxt = 1'b0;
      end else begin
        acc_nxt  = acc_upd;
        cnt_nxt  = cnt_upd;
        stop_nxt = stop_upd;
      end
    end
  end

  assign q_data.value  = acc_upd;
  assign q_data.digits = cnt_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

### hdl/dkrm_queue.sv
`timescale 1ns / 1ps
module dkrm_queue
  import dkrm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  key_entry_t wdata,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output key_entry_t rdata
);

  // two-entry FIFO between parser and divide engine
  key_entry_t  mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign valid   = (count_r != 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hdl/dkrm_back.sv
`timescale 1ns / 1ps
module dkrm_back
  import dkrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  key_entry_t       q_data,
  output logic             q_pop,
  input  logic [CNT_W-1:0] width_eff,
  input  logic [VAL_W-1:0] divisor,
  output logic             res_valid,
  output logic [VAL_W-1:0] res_data,
  input  logic             res_pop
);

  bk_state_t        state_r, state_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;     // padded value, then quotient
  logic [CNT_W-1:0] cnt_r, cnt_nxt;     // digit count, then bit index
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] res_r, res_nxt;
  logic             res_vld_r, res_vld_nxt;
  logic [VAL_W:0]   rem_sh, rem_sub;
  logic             ge;

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {rem_r, val_r[VAL_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    state_nxt   = state_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r;
    q_pop       = 1'b0;

    if (res_pop && res_vld_r) begin
      res_vld_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          val_nxt   = q_data.value;
          cnt_nxt   = q_data.digits;
          state_nxt = BK_PAD;
        end
      end
      BK_PAD: begin
        if (cnt_r < width_eff) begin
          val_nxt = times10(val_r);
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        rem_nxt = ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        val_nxt = {val_r[VAL_W-2:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == CNT_SAT) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!res_vld_r || res_pop) begin
          res_nxt     = val_r;
          res_vld_nxt = 1'b1;
          state_nxt   = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  assign res_valid = res_vld_r;
  assign res_data  = res_r;

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

endmodule

### hdl/decimal_key_range_mapper_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                                          Transfer when
// input     in         in_key_byte, in_byte_present, in_last_byte      in_push && !in_full
// result    out        out_range_id                                    out_pop && !out_empty
// config    in         cfg_we, cfg_index, cfg_wdata                    cfg_we
//
// Key bytes are parsed at one per cycle while in_full is low. At a key end the
// back end pads the value, multiplying by ten once per cycle, then divides with
// a restoring divider retiring one quotient bit per cycle.
// A two-entry queue between parser and divider lets both stall independently;
// in_full rises only while that queue is full.
// rst_n is synchronous, active low; it restores bucket divisor = 1, digit span = 16.
module decimal_key_range_mapper_core
  import dkrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_push,
  output logic             in_full,
  input  logic [7:0]       in_key_byte,
  input  logic             in_byte_present,
  input  logic             in_last_byte,
  // result channel
  output logic             out_empty,
  input  logic             out_pop,
  output logic [VAL_W-1:0] out_range_id,
  // configuration
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [VAL_W-1:0] cfg_wdata
);

  logic [VAL_W-1:0] bucket_div_r, bucket_div_nxt;
  logic [KW_W-1:0]  digit_span_r, digit_span_nxt;
  logic [CNT_W-1:0] width_eff;
  logic [CNT_W-1:0] width_raw;
  logic [VAL_W-1:0] divisor;

  logic       in_xfer;
  logic       q_push, q_full, q_pop, q_valid;
  key_entry_t q_wdata, q_rdata;
  logic       res_valid;

  // config registers: the user must write them only while the block is idle; the block does not enforce this
  always_comb begin
    bucket_div_nxt = bucket_div_r;
    digit_span_nxt = digit_span_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BUCKET_DIV: bucket_div_nxt = cfg_wdata;
        CFG_DIGIT_SPAN: digit_span_nxt = cfg_wdata[KW_W-1:0];
        default: begin
          bucket_div_nxt = bucket_div_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_div_r <= RS_DEFAULT;
      digit_span_r <= KW_DEFAULT;
    end else begin
      bucket_div_r <= bucket_div_nxt;
      digit_span_r <= digit_span_nxt;
    end
  end

  // zero width means sixteen digits; zero range size means one
  assign width_raw = {1'b0, (digit_span_r == '0) ? KW_DEFAULT : digit_span_r};
  assign width_eff = (width_raw > MAX_PAD_DIGITS) ? MAX_PAD_DIGITS : width_raw;
  assign divisor   = (bucket_div_r == '0) ? RS_DEFAULT : bucket_div_r;

  assign in_full = q_full;
  assign in_xfer = in_push && !q_full;

  dkrm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_xfer),
    .key_byte     (in_key_byte),
    .byte_present (in_byte_present),
    .last_byte    (in_last_byte),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  dkrm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  dkrm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .width_eff (width_eff),
    .divisor   (divisor),
    .res_valid (res_valid),
    .res_data  (out_range_id),
    .res_pop   (out_pop)
  );

  assign out_empty = !res_valid;

  // parser never pushes a finished key into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("key pushed into full queue");

  // divider only pulls a key when one is waiting
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending after reset");

endmodule

### verif/decimal_key_range_mapper_core_tb.sv
`timescale 1ns / 1ps
module decimal_key_range_mapper_core_tb;
  import dkrm_pkg::*;

  // One byte-wide input transfer as the sender offers it
  typedef struct {
    logic [7:0] key_byte;
    logic       present;
    logic       last;
  } key_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [7:0]       in_key_byte = 8'd0;
  logic             in_byte_present = 1'b0;
  logic             in_last_byte = 1'b0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [VAL_W-1:0] out_range_id;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_BUCKET_DIV;
  logic [VAL_W-1:0] cfg_wdata = '0;

  // Items waiting for the sender; the front one is what in_* carries while in_push is high
  key_item_t        key_items_pending[$];
  // Range ids owed by the block, oldest first
  logic [VAL_W-1:0] range_ids_due[$];

  // Shadow of the block's registers and of the key being parsed
  logic [VAL_W-1:0] bucket_div_shadow = RS_DEFAULT;
  logic [KW_W-1:0]  digit_span_shadow = KW_DEFAULT;
  logic [VAL_W-1:0] key_value;
  logic [CNT_W-1:0] key_digits;
  bit               key_stopped;

  int               mismatch_count = 0;
  int               ids_received = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               hold_left = 0;
  logic [31:0]      rx_cycle = '0;

  decimal_key_range_mapper_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_key_byte    (in_key_byte),
    .in_byte_present(in_byte_present),
    .in_last_byte   (in_last_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_range_id   (out_range_id),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor: fold one accepted transfer into the key state; on the key's
  // last transfer pad to the key width, bucket, and queue the range id.
  function automatic void fold_key_item(input key_item_t it);
    logic [VAL_W-1:0] padded;
    logic [VAL_W-1:0] divisor;
    logic [7:0]       digit;
    int unsigned      width;
    if (it.present && !key_stopped) begin
      if (it.key_byte >= CHAR_ZERO && it.key_byte <= CHAR_NINE) begin
        digit = it.key_byte - CHAR_ZERO;
        key_value = key_value * 64'd10 + {56'd0, digit};
        if (key_digits != CNT_SAT) key_digits = key_digits + 1'b1;
      end else begin
        key_stopped = 1'b1;
      end
    end
    if (it.last) begin
      width = (digit_span_shadow == '0) ? 32'd16 : 32'(digit_span_shadow);
      if (width > 32'(MAX_PAD_DIGITS)) width = 32'(MAX_PAD_DIGITS);
      padded = key_value;
      for (int i = int'(key_digits); i < width; i++) padded = padded * 64'd10;
      divisor = (bucket_div_shadow == '0) ? 64'd1 : bucket_div_shadow;
      range_ids_due.insert(range_ids_due.size(), padded / divisor);
      key_value = '0;
      key_digits = '0;
      key_stopped = 1'b0;
    end
  endfunction

  // Sender: bursts of random length, random gaps between them (often none).
  // An offered item is held until it transfers.
  always @(posedge clk) begin : sender
    logic offer_next;
    if (!rst_n) begin
      in_push <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      offer_next = in_push;
      if (in_push && !in_full) begin
        fold_key_item(key_items_pending.pop_front());
        offer_next = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
      if (!offer_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (key_items_pending.size() != 0) begin
          offer_next = 1'b1;
          in_key_byte <= key_items_pending[0].key_byte;
          in_byte_present <= key_items_pending[0].present;
          in_last_byte <= key_items_pending[0].last;
        end
      end
      in_push <= offer_next;
    end
  end

  // Receiver: checks each transfer against the oldest owed range id.
  // Stall pattern rotates through none, light, heavy, periodic as rx_cycle[9:8] steps.
  // Twice it holds off for a long stretch so the block backs up into in_full.
  always @(posedge clk) begin : receiver
    logic             pop_next;
    logic [VAL_W-1:0] want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      rx_cycle = rx_cycle + 1;
      if (out_pop && !out_empty) begin
        if (range_ids_due.size() == 0) begin
          $display("%0t: range_id %h with none expected", $time, out_range_id);
          mismatch_count++;
        end else begin
          want = range_ids_due.pop_front();
          if (out_range_id !== want) begin
            $display("%0t: range_id mismatch: expected %h, actual %h",
                     $time, want, out_range_id);
            mismatch_count++;
          end
        end
        ids_received++;
        if (ids_received == 12 || ids_received == 50) hold_left = 700;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop_next = 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0: pop_next = 1'b1;
          2'd1: pop_next = ($urandom_range(0, 3) != 0);
          2'd2: pop_next = ($urandom_range(0, 3) == 0);
          default: pop_next = (rx_cycle[2:0] < 3'd3);
        endcase
      end
      out_pop <= pop_next;
    end
  end

  task automatic add_item(input logic [7:0] b, input logic present, input logic last);
    key_item_t it;
    it.key_byte = b;
    it.present = present;
    it.last = last;
    key_items_pending.insert(key_items_pending.size(), it);
  endtask

  // One random key. Mostly clean digit strings; some broken by a non-digit,
  // some ending on an absent byte, some empty, some raw noise bytes.
  // Absent non-last items are sprinkled in and not counted.
  task automatic queue_random_key(output int counted);
    int         shape;
    int         len;
    int         cut;
    logic [7:0] b;
    bit         absent_end;
    counted = 0;
    shape = $urandom_range(0, 99);
    if (shape < 6) begin
      add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      counted = 1;
    end else begin
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(21, 72) : $urandom_range(1, 12);
      cut = (shape < 22) ? $urandom_range(0, len - 1) : -1;
      absent_end = (shape >= 22 && shape < 34);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        if (shape >= 90) begin
          b = 8'($urandom_range(0, 255));
        end else if (i == cut) begin
          do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
        end else begin
          b = CHAR_ZERO + 8'($urandom_range(0, 9));
        end
        add_item(b, 1'b1, (i == len - 1) && !absent_end);
        counted++;
      end
      if (absent_end) begin
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        counted++;
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [VAL_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_BUCKET_DIV) bucket_div_shadow = data;
    else digit_span_shadow = data[KW_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Everything sent, every range id back, then room for a key end that is
  // still padding or dividing.
  task automatic wait_drained();
    while (key_items_pending.size() != 0 || in_push || range_ids_due.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin : stimulus
    int n_items;
    int n_key;
    key_value = '0;
    key_digits = '0;
    key_stopped = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed keys at reset settings
    add_item(8'h00, 1'b0, 1'b1);                      // empty key
    add_item(8'hFF, 1'b0, 1'b0);                      // absent byte, no key end
    for (int d = 9; d >= 0; d--) add_item(CHAR_ZERO + 8'(d), 1'b1, d == 0);
    add_item(CHAR_ZERO + 8'd5, 1'b1, 1'b0);           // digit, then just above '9'
    add_item(CHAR_NINE + 8'd1, 1'b1, 1'b0);
    add_item(CHAR_ZERO + 8'd7, 1'b1, 1'b0);           // ignored after the stop
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(CHAR_ZERO - 8'd1, 1'b1, 1'b0);           // just below '0' first
    add_item(CHAR_ZERO + 8'd3, 1'b1, 1'b1);
    add_item(8'h80, 1'b1, 1'b1);                      // high byte as the whole key
    add_item(CHAR_ZERO + 8'd4, 1'b1, 1'b0);           // key ends on an absent byte
    add_item(CHAR_ZERO + 8'd2, 1'b1, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);

    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        wait_drained();
        case (p)
          1: begin
            write_reg(CFG_BUCKET_DIV, '0);
            write_reg(CFG_DIGIT_SPAN, '0);
          end
          2: begin
            write_reg(CFG_BUCKET_DIV, '1);
            write_reg(CFG_DIGIT_SPAN, 64'd31);
          end
          3: begin
            write_reg(CFG_BUCKET_DIV, 64'($urandom_range(1, 1000)));
            write_reg(CFG_DIGIT_SPAN, 64'd1);
          end
          4: begin
            write_reg(CFG_BUCKET_DIV, {$urandom, $urandom} >> $urandom_range(0, 63));
            write_reg(CFG_DIGIT_SPAN, 64'($urandom_range(0, 31)));
          end
          default: begin
            write_reg(CFG_BUCKET_DIV, 64'($urandom_range(2, 20)));
            write_reg(CFG_DIGIT_SPAN, 64'($urandom_range(0, 31)));
          end
        endcase
        @(negedge clk);
      end
      n_items = 0;
      while (n_items < 80) begin
        queue_random_key(n_key);
        n_items += n_key;
      end
    end

    wait_drained();
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
hdl/dkrm_pkg.sv
hdl/dkrm_front.sv
hdl/dkrm_queue.sv
hdl/dkrm_back.sv
hdl/decimal_key_range_mapper_core.sv
verif/decimal_key_range_mapper_core_tb.sv
